// File: hw/rtl/hcmm_pkg.sv
// shared types, address constants and command codes for the handheld console memory map
// no dependencies; imported by every module of the block

package hcmm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int BANK_ADDR_W = 15;

    // default oam dma length and its upper limit
    localparam int DMA_BYTES_DEF = 160;
    localparam int DMA_MAX       = 160;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // address map
    localparam logic [ADDR_W-1:0] BANK_LIMIT  = 16'h8000;
    localparam logic [ADDR_W-1:0] EXT_LO      = 16'hA000;
    localparam logic [ADDR_W-1:0] EXT_HI      = 16'hBFFF;
    localparam logic [ADDR_W-1:0] WRAM_LO     = 16'hC000;
    localparam logic [ADDR_W-1:0] WRAM_HI     = 16'hDDFF;
    localparam logic [ADDR_W-1:0] ECHO_OFFSET = 16'h2000;
    localparam logic [ADDR_W-1:0] OAM_BASE    = 16'hFE00;
    localparam logic [ADDR_W-1:0] UNUSED_LO   = 16'hFEA0;
    localparam logic [ADDR_W-1:0] UNUSED_HI   = 16'hFEFF;
    localparam logic [ADDR_W-1:0] REG_JOYP    = 16'hFF00;
    localparam logic [ADDR_W-1:0] REG_DIV     = 16'hFF04;
    localparam logic [ADDR_W-1:0] REG_IF      = 16'hFF0F;
    localparam logic [ADDR_W-1:0] REG_NR52    = 16'hFF26;
    localparam logic [ADDR_W-1:0] REG_STAT    = 16'hFF41;
    localparam logic [ADDR_W-1:0] REG_DMA     = 16'hFF46;
    localparam logic [ADDR_W-1:0] REG_LOCK0   = 16'hFF76;
    localparam logic [ADDR_W-1:0] REG_LOCK1   = 16'hFF77;

    // read and merge masks
    localparam logic [DATA_W-1:0] OPEN_BUS  = 8'hFF;
    localparam logic [DATA_W-1:0] JOYP_READ = 8'h0F;
    localparam logic [DATA_W-1:0] IF_TOP    = 8'hE0;
    localparam logic [DATA_W-1:0] IF_MASK   = 8'h1F;
    localparam logic [DATA_W-1:0] STAT_KEEP = 8'h07;
    localparam logic [DATA_W-1:0] RO4_KEEP  = 8'h0F;

    // access commands on the input channel
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_STORE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_BANK,
        OP_READ_CONST,
        OP_READ_MEM,
        OP_READ_IF,
        OP_PLAIN,
        OP_ECHO,
        OP_RMW3,
        OP_RMW4,
        OP_DMA
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
    } t_op;

    // back status, for the checks at the top level
    typedef struct packed {
        logic pop;
        logic emit;
        logic dma;
    } t_back_stat;

endpackage

// File: hw/rtl/hcmm_front.sv
// front: classifies one access into a back-end operation
// depends on hcmm_pkg

module hcmm_front (
    input  logic [1:0]                 i_cmd,
    input  logic [hcmm_pkg::ADDR_W-1:0] i_address,
    input  logic [hcmm_pkg::DATA_W-1:0] i_write_data,
    input  logic                       i_ext_ram_enabled,
    output hcmm_pkg::t_op              o_op
);
    import hcmm_pkg::*;

    logic ext_off;

    assign ext_off = (i_address inside {[EXT_LO:EXT_HI]}) && !i_ext_ram_enabled;

    // decode the command and address into one operation
    always_comb begin
        o_op.kind = OP_NONE;
        o_op.addr = i_address;
        o_op.data = i_write_data;
        case (t_cmd'(i_cmd))
            CMD_READ: begin
                if (ext_off) begin
                    o_op.kind = OP_READ_CONST;
                    o_op.data = OPEN_BUS;
                end else if (i_address == REG_JOYP) begin
                    o_op.kind = OP_READ_CONST;
                    o_op.data = JOYP_READ;
                end else if (i_address == REG_IF) begin
                    o_op.kind = OP_READ_IF;
                end else begin
                    o_op.kind = OP_READ_MEM;
                end
            end
            CMD_WRITE: begin
                if (i_address < BANK_LIMIT) begin
                    o_op.kind = OP_BANK;
                end else if (i_address inside {[WRAM_LO:WRAM_HI]}) begin
                    o_op.kind = OP_ECHO;
                end else if (ext_off) begin
                    o_op.kind = OP_NONE;
                end else if (i_address inside {[UNUSED_LO:UNUSED_HI], REG_LOCK0, REG_LOCK1}) begin
                    o_op.kind = OP_NONE;
                end else if (i_address == REG_DMA) begin
                    o_op.kind = OP_DMA;
                end else if (i_address == REG_DIV) begin
                    o_op.kind = OP_PLAIN;
                    o_op.data = '0;
                end else if (i_address == REG_STAT) begin
                    o_op.kind = OP_RMW3;
                end else if (i_address inside {REG_NR52, REG_JOYP}) begin
                    o_op.kind = OP_RMW4;
                end else begin
                    o_op.kind = OP_PLAIN;
                end
            end
            CMD_STORE: begin
                o_op.kind = OP_PLAIN;
            end
            default: begin
                o_op.kind = OP_NONE;
            end
        endcase
    end

endmodule

// File: hw/rtl/hcmm_queue.sv
// short fifo of classified operations between front and back
// depends on hcmm_pkg

module hcmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcmm_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output hcmm_pkg::t_op o_op,
    output logic          o_valid
);
    import hcmm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_op              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// File: hw/rtl/hcmm_back.sv
// back: executes operations against the 64 KiB byte memory, runs oam dma,
// and holds the result register; depends on hcmm_pkg

module hcmm_back #(
    parameter int DMA_BYTES = hcmm_pkg::DMA_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  hcmm_pkg::t_op                   i_q_op,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hcmm_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_bank_write,
    output logic [hcmm_pkg::BANK_ADDR_W-1:0] o_bank_addr,
    output logic [hcmm_pkg::DATA_W-1:0]      o_bank_data,
    output hcmm_pkg::t_back_stat            o_stat
);
    import hcmm_pkg::*;

    localparam int DMA_N = (DMA_BYTES < DMA_MAX) ? DMA_BYTES : DMA_MAX;
    localparam int CNT_W = $clog2(DMA_N + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DMA_N);
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_ECHO,
        ST_DMA
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_cur, n_cur;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_W-1:0]      r_read_data, n_read_data;
    logic                   r_bank_write, n_bank_write;
    logic [BANK_ADDR_W-1:0] r_bank_addr, n_bank_addr;
    logic [DATA_W-1:0]      r_bank_data, n_bank_data;

    logic [DATA_W-1:0]      mem [MEM_DEPTH];
    logic [DATA_W-1:0]      r_rd_data;
    logic [ADDR_W-1:0]      raddr, waddr;
    logic [DATA_W-1:0]      wdata;
    logic                   we;
    logic                   slot_free, pop, emit;

    assign slot_free = !r_out_valid || i_out_ready;

    // next-state logic, memory port control and result formation
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_read_data  = r_read_data;
        n_bank_write = r_bank_write;
        n_bank_addr  = r_bank_addr;
        n_bank_data  = r_bank_data;
        pop          = 1'b0;
        emit         = 1'b0;
        we           = 1'b0;
        waddr        = r_cur.addr;
        wdata        = r_cur.data;
        raddr        = r_cur.addr;
        case (r_state)
            ST_IDLE: begin
                raddr = i_q_op.addr;
                if (i_q_valid && slot_free) begin
                    pop          = 1'b1;
                    n_cur        = i_q_op;
                    n_read_data  = '0;
                    n_bank_write = 1'b0;
                    n_bank_addr  = '0;
                    n_bank_data  = '0;
                    case (i_q_op.kind)
                        OP_BANK: begin
                            emit         = 1'b1;
                            n_bank_write = 1'b1;
                            n_bank_addr  = i_q_op.addr[BANK_ADDR_W-1:0];
                            n_bank_data  = i_q_op.data;
                        end
                        OP_READ_CONST: begin
                            emit        = 1'b1;
                            n_read_data = i_q_op.data;
                        end
                        OP_READ_MEM, OP_READ_IF: begin
                            n_state = ST_READ;
                        end
                        OP_PLAIN: begin
                            emit  = 1'b1;
                            we    = 1'b1;
                            waddr = i_q_op.addr;
                            wdata = i_q_op.data;
                        end
                        OP_ECHO: begin
                            emit    = 1'b1;
                            we      = 1'b1;
                            waddr   = i_q_op.addr + ECHO_OFFSET;
                            wdata   = i_q_op.data;
                            n_state = ST_ECHO;
                        end
                        OP_RMW3, OP_RMW4: begin
                            emit    = 1'b1;
                            n_state = ST_MERGE;
                        end
                        OP_DMA: begin
                            emit    = 1'b1;
                            n_cnt   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_DMA;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                emit    = 1'b1;
                n_state = ST_IDLE;
                if (r_cur.kind == OP_READ_IF) begin
                    n_read_data = (r_rd_data & IF_MASK) | IF_TOP;
                end else begin
                    n_read_data = r_rd_data;
                end
            end
            ST_MERGE: begin
                we      = 1'b1;
                n_state = ST_IDLE;
                if (r_cur.kind == OP_RMW3) begin
                    wdata = (r_cur.data & ~STAT_KEEP) | (r_rd_data & STAT_KEEP);
                end else begin
                    wdata = (r_cur.data & ~RO4_KEEP) | (r_rd_data & RO4_KEEP);
                end
            end
            ST_ECHO: begin
                we      = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DMA: begin
                // read source byte n while writing byte n-1 into oam
                raddr = {r_cur.data, {(ADDR_W-DATA_W){1'b0}}} + ADDR_W'(r_cnt);
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = OAM_BASE + ADDR_W'(r_cnt) - ADDR_W'(1);
                    wdata = r_rd_data;
                end
                if (r_cnt != CNT_LAST) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // copy done, store the dma register itself
                        we      = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
        end
        r_cur        <= n_cur;
        r_read_data  <= n_read_data;
        r_bank_write <= n_bank_write;
        r_bank_addr  <= n_bank_addr;
        r_bank_data  <= n_bank_data;
    end

    // byte memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    assign o_q_pop      = pop;
    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_bank_write = r_bank_write;
    assign o_bank_addr  = r_bank_addr;
    assign o_bank_data  = r_bank_data;
    assign o_stat.pop   = pop;
    assign o_stat.emit  = emit;
    assign o_stat.dma   = (r_state == ST_DMA);

endmodule

// File: hw/rtl/handheld_console_memory_map.sv
// 64 KiB byte memory map with bank forwarding and oam dma, top level
// instantiates hcmm_front, hcmm_queue and hcmm_back; depends on hcmm_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one access: read, cpu
//   write with map rules, or direct store. output channel (o_out_valid /
//   i_out_ready) returns exactly one result per access, in order: the byte
//   read (zero for writes) and the bank controller write fields.
//   an accepted access enters a two-entry queue; the back end pops it once
//   it is idle and the output register is free. writes, bank writes and
//   constant reads put their result in the output register at pop; memory
//   reads go through the registered memory read (ST_READ) first.
//   pace: the byte memory with its one write port sets it. bank writes,
//   stores, plain writes and constant reads finish at pop; memory reads,
//   work ram writes (echo copy) and read-merge register writes also pass
//   through ST_READ, ST_ECHO or ST_MERGE; a write to the dma register holds
//   the back end in ST_DMA while the copy into oam runs one byte per cycle.
//   a stalled receiver holds the output register; the queue keeps taking
//   accesses until it is full, then o_in_ready drops.
//   reset empties the queue and output register; memory contents are
//   undefined until written, and no clearing pass runs.

module handheld_console_memory_map #(
    parameter int DMA_BYTES = hcmm_pkg::DMA_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [hcmm_pkg::ADDR_W-1:0]      i_address,
    input  logic [hcmm_pkg::DATA_W-1:0]      i_write_data,
    input  logic                            i_ext_ram_enabled,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hcmm_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_bank_write,
    output logic [hcmm_pkg::BANK_ADDR_W-1:0] o_bank_addr,
    output logic [hcmm_pkg::DATA_W-1:0]      o_bank_data
);
    import hcmm_pkg::*;

    t_op        front_op, q_op;
    logic       q_full, q_valid, q_pop, push;
    t_back_stat back_stat;

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && o_in_ready;

    // classify the incoming access
    hcmm_front u_front (
        .i_cmd             (i_cmd),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_ext_ram_enabled (i_ext_ram_enabled),
        .o_op              (front_op)
    );

    // decouple front and back
    hcmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_valid (q_valid)
    );

    // execute against memory
    hcmm_back #(
        .DMA_BYTES (DMA_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_op       (q_op),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_bank_write (o_bank_write),
        .o_bank_addr  (o_bank_addr),
        .o_bank_data  (o_bank_data),
        .o_stat       (back_stat)
    );

    // a new result never overwrites one still waiting for transfer
    ap_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.emit |-> (!o_out_valid || i_out_ready))
        else $error("result written over a pending transfer");

    // nothing leaves the queue while the oam copy runs
    ap_dma_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.dma |-> !back_stat.pop)
        else $error("queue popped during dma");

    // reset leaves no result pending and no copy running
    ap_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !back_stat.dma))
        else $error("state not cleared by reset");

endmodule

// File: verif/handheld_console_memory_map_tb.sv
// testbench for handheld_console_memory_map: directed and random accesses with a scoreboard
// depends on hcmm_pkg and the handheld_console_memory_map rtl; self-checking, no files read

module handheld_console_memory_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcmm_pkg::*;

    localparam int DMA_LEN       = DMA_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 900;
    localparam int NO_XFER_LIMIT = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTED   = 60;

    // idle modes of the stimulus phases
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECVR  = 2;
    localparam int IDLE_BOTH   = 3;

    typedef struct packed {
        logic [DATA_W-1:0]      rd;
        logic                   bw;
        logic [BANK_ADDR_W-1:0] ba;
        logic [DATA_W-1:0]      bd;
    } t_map_result;

    // memory map predictor plus queue of expected results
    class access_scoreboard;
        bit [7:0]    mem [65536];
        bit          written [65536];
        int unsigned page_fill [256];
        bit [15:0]   written_addrs [$];
        bit [7:0]    full_pages [$];
        t_map_result expected_q [$];
        int unsigned errors;
        int unsigned results;
        int unsigned accesses;
        int unsigned dma_copies;

        // raw byte store, tracks which bytes and which dma source pages are known
        function void put_byte(bit [15:0] a, bit [7:0] v);
            mem[a] = v;
            if (!written[a]) begin
                written[a] = 1'b1;
                written_addrs.push_back(a);
                if (a[7:0] < DMA_LEN) begin
                    page_fill[a[15:8]]++;
                    if (page_fill[a[15:8]] == DMA_LEN)
                        full_pages.push_back(a[15:8]);
                end
            end
        endfunction

        function bit [7:0] cpu_load(bit [15:0] a, bit ext);
            if (a >= EXT_LO && a <= EXT_HI && !ext)
                return OPEN_BUS;
            if (a == REG_JOYP)
                return JOYP_READ;
            if (a == REG_IF)
                return (mem[a] & IF_MASK) | IF_TOP;
            return mem[a];
        endfunction

        // cpu write above the bank area, with the map rules
        function void cpu_store(bit [15:0] a, bit [7:0] d, bit ext);
            bit [7:0]  v;
            bit [15:0] src;
            int        i;
            v = d;
            if (a >= WRAM_LO && a <= WRAM_HI)
                put_byte(a + ECHO_OFFSET, d);
            if (a >= EXT_LO && a <= EXT_HI && !ext)
                return;
            if (a >= UNUSED_LO && a <= UNUSED_HI)
                return;
            if (a == REG_LOCK0 || a == REG_LOCK1)
                return;
            // oam copy runs upward before the dma register itself is stored
            if (a == REG_DMA) begin
                src = {d, 8'h00};
                for (i = 0; i < DMA_LEN; i++)
                    put_byte(OAM_BASE + i, mem[src + i]);
                dma_copies++;
            end
            if (a == REG_DIV)
                v = '0;
            else if (a == REG_STAT)
                v = (d & ~STAT_KEEP) | (mem[a] & STAT_KEEP);
            else if (a == REG_NR52 || a == REG_JOYP)
                v = (d & ~RO4_KEEP) | (mem[a] & RO4_KEEP);
            put_byte(a, v);
        endfunction

        function void note_access(t_cmd c, bit [15:0] a, bit [7:0] d, bit ext);
            t_map_result r;
            r = '0;
            accesses++;
            case (c)
                CMD_READ: r.rd = cpu_load(a, ext);
                CMD_WRITE: begin
                    if (a < BANK_LIMIT) begin
                        r.bw = 1'b1;
                        r.ba = a[BANK_ADDR_W-1:0];
                        r.bd = d;
                    end else begin
                        cpu_store(a, d, ext);
                    end
                end
                CMD_STORE: put_byte(a, d);
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch: %s", msg);
        endtask

        task check_result(t_map_result got);
            t_map_result want;
            results++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending", results));
                return;
            end
            want = expected_q.pop_front();
            if (got.rd !== want.rd)
                report_mismatch($sformatf("result %0d read_data %02h, want %02h",
                                          results, got.rd, want.rd));
            if (got.bw !== want.bw)
                report_mismatch($sformatf("result %0d bank_write %0b, want %0b",
                                          results, got.bw, want.bw));
            if (got.ba !== want.ba)
                report_mismatch($sformatf("result %0d bank_addr %04h, want %04h",
                                          results, got.ba, want.ba));
            if (got.bd !== want.bd)
                report_mismatch($sformatf("result %0d bank_data %02h, want %02h",
                                          results, got.bd, want.bd));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             cmd;
    logic [ADDR_W-1:0]      address;
    logic [DATA_W-1:0]      write_data;
    logic                   ext_ram_enabled;
    logic                   out_valid;
    logic                   out_ready;
    logic [DATA_W-1:0]      read_data;
    logic                   bank_write;
    logic [BANK_ADDR_W-1:0] bank_addr;
    logic [DATA_W-1:0]      bank_data;

    access_scoreboard sb;
    int               idle_mode;
    bit               hold_req;
    int unsigned      hold_left;
    int unsigned      sent;
    int unsigned      no_xfer_cycles;
    int               fills;

    handheld_console_memory_map dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (cmd),
        .i_address         (address),
        .i_write_data      (write_data),
        .i_ext_ram_enabled (ext_ram_enabled),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_read_data       (read_data),
        .o_bank_write      (bank_write),
        .o_bank_addr       (bank_addr),
        .o_bank_data       (bank_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 57;
            IDLE_BOTH:   return $urandom_range(0, 99) < 17;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECVR: return $urandom_range(0, 99) < 57;
            IDLE_BOTH:  return $urandom_range(0, 99) < 17;
            default:    return 1'b0;
        endcase
    endfunction

    // receiver ready, with the long hold-off counted here
    initial begin
        out_ready = 1'b0;
        hold_left = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_left == 0 && hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !receiver_stall();
            end
        end
    end

    // result check and no-transfer watchdog
    always @(posedge clk) begin : monitor
        t_map_result seen;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                seen.rd = read_data;
                seen.bw = bank_write;
                seen.ba = bank_addr;
                seen.bd = bank_data;
                sb.check_result(seen);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                no_xfer_cycles = 0;
            else
                no_xfer_cycles++;
            if (no_xfer_cycles >= NO_XFER_LIMIT) begin
                $display("watchdog: %0d cycles with no transfer", no_xfer_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // one access transfer on the input channel
    task automatic send_access(t_cmd c, bit [15:0] a, bit [7:0] d, bit ext);
        @(negedge clk);
        while (sender_gap()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        address         <= a;
        write_data      <= d;
        ext_ram_enabled <= ext;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(c, a, d, ext);
        sent++;
    endtask

    // steer away from reads and merges of unwritten bytes and from dma of partly written pages
    task automatic send_legal(t_cmd c, bit [15:0] a, bit [7:0] d, bit ext);
        if (c == CMD_READ) begin
            if (!(a >= EXT_LO && a <= EXT_HI && !ext) && a != REG_JOYP && !sb.written[a])
                a = sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
        end else if (c == CMD_WRITE) begin
            if (a == REG_DMA && sb.page_fill[d] != DMA_LEN)
                d = sb.full_pages[$urandom_range(0, sb.full_pages.size() - 1)];
            else if ((a == REG_STAT || a == REG_NR52 || a == REG_JOYP) && !sb.written[a])
                c = CMD_STORE;
        end
        send_access(c, a, d, ext);
    endtask

    function automatic t_cmd pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CMD_READ;
        else if (r < 75)
            return CMD_WRITE;
        else if (r < 95)
            return CMD_STORE;
        return CMD_NONE;
    endfunction

    function automatic bit [15:0] pick_register();
        case ($urandom_range(0, 7))
            0: return REG_JOYP;
            1: return REG_DIV;
            2: return REG_IF;
            3: return REG_NR52;
            4: return REG_STAT;
            5: return REG_DMA;
            6: return REG_LOCK0;
            default: return REG_LOCK1;
        endcase
    endfunction

    // region boundaries and special registers
    function automatic bit [15:0] pick_edge();
        case ($urandom_range(0, 13))
            0: return 16'h0000;
            1: return BANK_LIMIT - 1;
            2: return BANK_LIMIT;
            3: return EXT_LO;
            4: return EXT_HI;
            5: return WRAM_LO;
            6: return WRAM_HI;
            7: return WRAM_HI + 1;
            8: return WRAM_HI + ECHO_OFFSET;
            9: return UNUSED_LO - 1;
            10: return UNUSED_LO;
            11: return UNUSED_HI;
            12: return 16'hFFFF;
            default: return pick_register();
        endcase
    endfunction

    function automatic bit [15:0] pick_address();
        case ($urandom_range(0, 11))
            0: return $urandom_range(0, BANK_LIMIT - 1);
            1: return $urandom_range(BANK_LIMIT, EXT_LO - 1);
            2: return $urandom_range(EXT_LO, EXT_HI);
            3: return $urandom_range(WRAM_LO, WRAM_HI);
            4: return $urandom_range(WRAM_HI + 1, 16'hDFFF);
            5: return $urandom_range(16'hE000, OAM_BASE - 1);
            6: return $urandom_range(OAM_BASE, UNUSED_LO - 1);
            7: return $urandom_range(UNUSED_LO, UNUSED_HI);
            8: return pick_edge();
            9: return $urandom_range(REG_JOYP, 16'hFF7F);
            10: return $urandom_range(16'hFF80, 16'hFFFF);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    task automatic random_single();
        send_legal(pick_cmd(), pick_address(), $urandom, $urandom);
    endtask

    // a few writes followed by reads of the same bytes, or of known bytes where those were never written
    task automatic write_readback();
        bit [15:0] addrs [4];
        int        n;
        int        i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            addrs[i] = pick_address();
            send_legal($urandom_range(0, 1) ? CMD_WRITE : CMD_STORE, addrs[i], $urandom,
                       $urandom_range(0, 3) != 0);
        end
        for (i = 0; i < n; i++)
            send_legal(CMD_READ, addrs[i], $urandom, $urandom_range(0, 3) != 0);
    endtask

    task automatic register_touch();
        bit [15:0] a;
        a = pick_register();
        if ($urandom_range(0, 1))
            send_access(CMD_STORE, a, $urandom, $urandom);
        send_legal(CMD_WRITE, a, $urandom, $urandom);
        send_legal(CMD_READ, a, $urandom, $urandom);
    endtask

    task automatic work_ram_mirror();
        bit [15:0] a;
        a = $urandom_range(WRAM_LO, WRAM_HI);
        send_legal(CMD_WRITE, a, $urandom, $urandom);
        send_legal(CMD_READ, a + ECHO_OFFSET, $urandom, $urandom);
        send_legal(CMD_READ, a, $urandom, $urandom);
    endtask

    // dma from a known page, then sample the oam
    task automatic dma_copy();
        int i;
        send_legal(CMD_WRITE, REG_DMA, $urandom, $urandom);
        for (i = 0; i < 3; i++)
            send_legal(CMD_READ, OAM_BASE + $urandom_range(0, DMA_LEN - 1), $urandom, $urandom);
    endtask

    task automatic fill_and_copy();
        bit [7:0] page;
        int       i;
        page = $urandom;
        for (i = 0; i < DMA_LEN; i++)
            send_access(CMD_STORE, {page, i[7:0]}, $urandom, $urandom);
        send_access(CMD_WRITE, REG_DMA, page, $urandom);
        send_legal(CMD_READ, OAM_BASE + DMA_LEN - 1, $urandom, $urandom);
        fills++;
    endtask

    task automatic directed_accesses();
        send_access(CMD_STORE, 16'hFFFF, 8'hFF, 1'b1);
        send_access(CMD_READ, 16'h0000, 8'hFF, 1'b1);
        // bank controller forwarding at both ends
        send_access(CMD_WRITE, 16'h0000, 8'hA5, 1'b0);
        send_access(CMD_WRITE, BANK_LIMIT - 1, 8'h00, 1'b1);
        // external ram enable
        send_access(CMD_READ, EXT_LO, 8'h00, 1'b0);
        send_access(CMD_WRITE, EXT_HI, 8'h5A, 1'b1);
        send_access(CMD_WRITE, EXT_HI, 8'h12, 1'b0);
        send_access(CMD_READ, EXT_HI, 8'h00, 1'b1);
        // work ram echo at the top of the mirrored range
        send_access(CMD_WRITE, WRAM_HI, 8'h3C, 1'b1);
        send_access(CMD_READ, WRAM_HI + ECHO_OFFSET, 8'h00, 1'b0);
        // unused area and locked register drop cpu writes
        send_access(CMD_STORE, UNUSED_LO, 8'h11, 1'b0);
        send_access(CMD_WRITE, UNUSED_LO, 8'h22, 1'b1);
        send_access(CMD_READ, UNUSED_LO, 8'h00, 1'b1);
        send_access(CMD_STORE, REG_LOCK0, 8'h33, 1'b0);
        send_access(CMD_WRITE, REG_LOCK0, 8'h44, 1'b0);
        send_access(CMD_READ, REG_LOCK0, 8'h00, 1'b0);
        // divider clear, kept low bits, joypad and interrupt flag reads
        send_access(CMD_WRITE, REG_DIV, 8'h99, 1'b0);
        send_access(CMD_READ, REG_DIV, 8'h00, 1'b0);
        send_access(CMD_STORE, REG_STAT, 8'hFF, 1'b0);
        send_access(CMD_WRITE, REG_STAT, 8'h00, 1'b0);
        send_access(CMD_READ, REG_STAT, 8'h00, 1'b0);
        send_access(CMD_STORE, REG_NR52, 8'h0A, 1'b0);
        send_access(CMD_WRITE, REG_NR52, 8'hF5, 1'b0);
        send_access(CMD_READ, REG_NR52, 8'h00, 1'b0);
        send_access(CMD_STORE, REG_JOYP, 8'h03, 1'b0);
        send_access(CMD_WRITE, REG_JOYP, 8'hF0, 1'b0);
        send_access(CMD_READ, REG_JOYP, 8'h00, 1'b0);
        send_access(CMD_STORE, REG_IF, 8'h00, 1'b0);
        send_access(CMD_READ, REG_IF, 8'h00, 1'b0);
        // oam dma from the preloaded page, then a meaningless command
        send_access(CMD_WRITE, REG_DMA, 8'h00, 1'b0);
        send_access(CMD_READ, OAM_BASE + DMA_LEN - 1, 8'h00, 1'b0);
        send_access(CMD_NONE, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    // main sequence
    initial begin : stimulus
        int phase;
        int i;
        int r;
        int unsigned target;
        sb              = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = CMD_READ;
        address         = '0;
        write_data      = '0;
        ext_ram_enabled = 1'b0;
        idle_mode       = IDLE_NONE;
        hold_req        = 1'b0;
        sent            = 0;
        no_xfer_cycles  = 0;
        fills           = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // preload the first page so reads and the first dma have known data
        for (i = 0; i < DMA_LEN; i++)
            send_access(CMD_STORE, i[15:0], $urandom, $urandom);
        directed_accesses();

        for (phase = IDLE_NONE; phase <= IDLE_BOTH; phase++) begin
            idle_mode = phase;
            if (phase == IDLE_NONE)
                hold_req = 1'b1;
            target = sent + RANDOM_ITEMS / 4;
            while (sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    random_single();
                else if (r < 60)
                    write_readback();
                else if (r < 75)
                    register_touch();
                else if (r < 88)
                    work_ram_mirror();
                else if (r < 97 || fills >= 2)
                    dma_copy();
                else
                    fill_and_copy();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d accesses, %0d results checked, %0d oam copies, %0d mismatches",
                 sb.accesses, sb.results, sb.dma_copies, sb.errors);
        $display("idle phases: none, sender gaps, receiver stalls, both; one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/hcmm_pkg.sv
hw/rtl/hcmm_front.sv
hw/rtl/hcmm_queue.sv
hw/rtl/hcmm_back.sv
hw/rtl/handheld_console_memory_map.sv
verif/handheld_console_memory_map_tb.sv
